>>> design/dqs_pkg.sv
package dqs_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 5;

    localparam logic [OP_W-1:0] OP_INSERT_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR        = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH       = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN
    } t_state;

    // ring position of base plus offset, offset no larger than the capacity
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(CAPACITY)) begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return IDX_W'(sum);
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] res;
        if (base == '0) begin
            res = IDX_W'(CAPACITY - 1);
        end else begin
            res = base - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

>>> design/deque_with_membership_search_core.sv
// channel | valid      | stall      | payload
// input   | i_in_valid | o_in_stall | i_opcode, i_data_in
// output  | o_out_valid| i_out_stall| o_status, o_data_out, o_found, o_occupancy
//
// one transaction at a time: insert, append, clear, unused opcodes and a remove or
// search of an empty queue end in the exec state, a remove of a held entry adds
// the read state (one ram read), a search of a non-empty queue runs the scan state,
// one entry compared per cycle through the single ram read port
// i_rst_n is synchronous, active low; it empties the queue, the ram is not cleared
// the result register frees the input side; a transaction waits in its last
// state while a result is still held under i_out_stall
module deque_with_membership_search_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dqs_pkg::OP_W-1:0]            i_opcode,
    input  logic signed [dqs_pkg::DATA_W-1:0]   i_data_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dqs_pkg::STAT_W-1:0]          o_status,
    output logic signed [dqs_pkg::DATA_W-1:0]   o_data_out,
    output logic                                o_found,
    output logic [dqs_pkg::OCC_W-1:0]           o_occupancy
);
    import dqs_pkg::*;

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [DATA_W-1:0]   r_data, n_data;
    logic [IDX_W-1:0]    r_front, n_front;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [DATA_W-1:0]   r_dout, n_dout;
    logic                r_found, n_found;
    logic [OCC_W-1:0]    r_occ, n_occ;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic [IDX_W-1:0]    rd_addr;
    logic [DATA_W-1:0]   rd_data;

    logic                accept;
    logic                out_free;
    logic                full;
    logic                empty;
    logic                hit;
    logic                last;
    logic                done;
    logic [STAT_W-1:0]   res_status;
    logic [DATA_W-1:0]   res_dout;
    logic                res_found;
    logic [IDX_W-1:0]    rem_addr;
    logic [IDX_W-1:0]    front_dec;

    dqs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign full      = (r_count >= CNT_W'(CAPACITY));
    assign empty     = (r_count == '0);
    assign hit       = (rd_data == r_data);
    assign last      = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));
    assign rem_addr  = ring_add(r_front, r_count - CNT_W'(1));
    assign front_dec = ring_dec(r_front);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if ((r_op == OP_REMOVE_BACK) && !empty) begin
                    n_state = S_READ;
                end else if ((r_op == OP_SEARCH) && !empty) begin
                    n_state = S_SCAN;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if ((hit || last) && out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_op        = r_op;
        n_data      = r_data;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_dout      = r_dout;
        n_found     = r_found;
        n_occ       = r_occ;
        wr_en       = 1'b0;
        wr_addr     = r_front;
        wr_data     = r_data;
        rd_addr     = rem_addr;
        done        = 1'b0;
        res_status  = ST_OK;
        res_dout    = '0;
        res_found   = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op   = i_opcode;
                    n_data = i_data_in;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_INSERT_FRONT: begin
                        done = out_free;
                        if (full) begin
                            res_status = ST_FULL;
                        end else if (out_free) begin
                            wr_en   = 1'b1;
                            wr_addr = front_dec;
                            n_front = front_dec;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    OP_APPEND_BACK: begin
                        done = out_free;
                        if (full) begin
                            res_status = ST_FULL;
                        end else if (out_free) begin
                            wr_en   = 1'b1;
                            wr_addr = ring_add(r_front, r_count);
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    OP_REMOVE_BACK: begin
                        if (empty) begin
                            done       = out_free;
                            res_status = ST_EMPTY;
                        end
                    end
                    OP_CLEAR: begin
                        done = out_free;
                        if (out_free) begin
                            n_count = '0;
                            n_front = '0;
                        end
                    end
                    OP_SEARCH: begin
                        n_idx   = '0;
                        rd_addr = r_front;
                        if (empty) begin
                            done = out_free;
                        end
                    end
                    default: begin
                        done = out_free;
                    end
                endcase
            end
            S_READ: begin
                if (out_free) begin
                    done     = 1'b1;
                    res_dout = rd_data;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            S_SCAN: begin
                if (hit || last) begin
                    rd_addr   = ring_add(r_front, CNT_W'(r_idx));
                    done      = out_free;
                    res_found = hit;
                end else begin
                    rd_addr = ring_add(r_front, CNT_W'(r_idx) + CNT_W'(1));
                    n_idx   = r_idx + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase

        if (done) begin
            n_out_valid = 1'b1;
            n_status    = res_status;
            n_dout      = res_dout;
            n_found     = res_found;
            n_occ       = OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_data   <= n_data;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_dout   <= n_dout;
        r_found  <= n_found;
        r_occ    <= n_occ;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data_out  = r_dout;
    assign o_found     = r_found;
    assign o_occupancy = r_occ;

endmodule

>>> design/dqs_ram.sv
module dqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> tb/deque_result_checker.sv
`timescale 1ns / 1ps
module deque_result_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [dqs_pkg::OP_W-1:0]           i_opcode,
    input  logic signed [dqs_pkg::DATA_W-1:0]  i_data_in,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [dqs_pkg::STAT_W-1:0]         i_status,
    input  logic signed [dqs_pkg::DATA_W-1:0]  i_data_out,
    input  logic                               i_found,
    input  logic [dqs_pkg::OCC_W-1:0]          i_occupancy,
    output int                                 o_mismatch_count,
    output int                                 o_pending
);
    import dqs_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [DATA_W-1:0]  data_out;
        logic                      found;
        logic [OCC_W-1:0]          occupancy;
    } t_deque_result;

    logic signed [DATA_W-1:0] held_entries [CAPACITY];
    int front_slot = 0;
    int held_count = 0;
    int mismatch_total = 0;
    int pending_total = 0;
    t_deque_result awaited_results[$];

    assign o_mismatch_count = mismatch_total;
    assign o_pending        = pending_total;

    function automatic t_deque_result deque_apply(input logic [OP_W-1:0] op,
                                                  input logic signed [DATA_W-1:0] value);
        t_deque_result res;
        int k;
        res.status    = ST_OK;
        res.data_out  = '0;
        res.found     = 1'b0;
        res.occupancy = '0;
        case (op)
            OP_INSERT_FRONT: begin
                if (held_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    front_slot = (front_slot + CAPACITY - 1) % CAPACITY;
                    held_entries[front_slot] = value;
                    held_count++;
                end
            end
            OP_APPEND_BACK: begin
                if (held_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    held_entries[(front_slot + held_count) % CAPACITY] = value;
                    held_count++;
                end
            end
            OP_REMOVE_BACK: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data_out = held_entries[(front_slot + held_count - 1) % CAPACITY];
                    held_count--;
                end
            end
            OP_CLEAR: begin
                held_count = 0;
                front_slot = 0;
            end
            OP_SEARCH: begin
                for (k = 0; k < held_count; k++) begin
                    if (held_entries[(front_slot + k) % CAPACITY] == value) begin
                        res.found = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.occupancy = OCC_W'(held_count);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_deque_result want;
        if (!i_rst_n) begin
            front_slot = 0;
            held_count = 0;
            awaited_results.delete();
        end else begin
            // request first, so a result at the same edge still meets the older one
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(deque_apply(i_opcode, i_data_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no transaction outstanding: status %0d data_out %0d",
                           i_status, i_data_out);
                    mismatch_total++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        mismatch_total++;
                    end
                    if (i_data_out !== want.data_out) begin
                        $error("data_out mismatch: expected %0d, actual %0d",
                               want.data_out, i_data_out);
                        mismatch_total++;
                    end
                    if (i_found !== want.found) begin
                        $error("found mismatch: expected %0d, actual %0d",
                               want.found, i_found);
                        mismatch_total++;
                    end
                    if (i_occupancy !== want.occupancy) begin
                        $error("occupancy mismatch: expected %0d, actual %0d",
                               want.occupancy, i_occupancy);
                        mismatch_total++;
                    end
                end
            end
        end
        pending_total <= awaited_results.size();
    end

endmodule

>>> tb/tb_deque_with_membership_search_core.sv
`timescale 1ns / 1ps
module tb_deque_with_membership_search_core;
    import dqs_pkg::*;

    localparam int ITEM_TARGET      = 1350;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int RECENT_DEPTH     = 24;

    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7fff_ffff;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED,
        PH_NOISE
    } t_phase_kind;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [OP_W-1:0]           i_opcode = '0;
    logic signed [DATA_W-1:0]  i_data_in = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [STAT_W-1:0]         o_status;
    logic signed [DATA_W-1:0]  o_data_out;
    logic                      o_found;
    logic [OCC_W-1:0]          o_occupancy;

    int mismatch_count;
    int pending_results;
    int burst_left = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    bit long_hold_req = 1'b0;
    logic signed [DATA_W-1:0] recent_values[$];

    deque_with_membership_search_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_found     (o_found),
        .o_occupancy (o_occupancy)
    );

    deque_result_checker result_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_data_in        (i_data_in),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_data_out       (o_data_out),
        .i_found          (o_found),
        .i_occupancy      (o_occupancy),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_results)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver stall pattern, with a long hold-off when asked for
    initial begin : receiver
        int run_len;
        int stall_pct;
        int j;
        forever begin
            run_len   = $urandom_range(8, 64);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 75);
            for (j = 0; j < run_len; j++) begin
                @(negedge i_clk);
                if (long_hold_req) begin
                    long_hold_req = 1'b0;
                    i_out_stall <= 1'b1;
                    repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                end
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = MOST_NEGATIVE;
            1: v = MOST_POSITIVE;
            2: v = $signed($urandom_range(0, 7)) - 4;
            3: begin
                if (recent_values.size() != 0) begin
                    v = recent_values[$urandom_range(0, recent_values.size() - 1)];
                end else begin
                    v = $urandom();
                end
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // one transaction, with the sender working in bursts
    task automatic push_request(input logic [OP_W-1:0] op,
                                input logic signed [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30)
                                                     : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_data_in  <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op <= OP_SEARCH) begin
            items_sent++;
        end
        if (op == OP_INSERT_FRONT || op == OP_APPEND_BACK) begin
            recent_values.push_back(value);
            if (recent_values.size() > RECENT_DEPTH) begin
                void'(recent_values.pop_front());
            end
        end
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_phase_kind kind;
        logic [OP_W-1:0] op;
        logic signed [DATA_W-1:0] value;
        int phase_len;
        int r;
        int k;
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue corners, extremes and unused opcodes
        push_request(OP_REMOVE_BACK, MOST_POSITIVE);
        push_request(OP_SEARCH, '0);
        push_request(OP_CLEAR, MOST_NEGATIVE);
        push_request(OP_SPARE_LO, -1);
        push_request(OP_INSERT_FRONT, MOST_NEGATIVE);
        push_request(OP_APPEND_BACK, MOST_POSITIVE);
        push_request(OP_INSERT_FRONT, -1);
        push_request(OP_APPEND_BACK, '0);
        push_request(OP_SEARCH, MOST_NEGATIVE);
        push_request(OP_SEARCH, 1);
        push_request(OP_SEARCH, '0);
        push_request(OP_SPARE_MID, MOST_POSITIVE);
        push_request(OP_REMOVE_BACK, '0);
        push_request(OP_REMOVE_BACK, -1);
        push_request(OP_SPARE_HI, MOST_NEGATIVE);
        push_request(OP_REMOVE_BACK, '0);
        push_request(OP_REMOVE_BACK, '0);
        push_request(OP_REMOVE_BACK, '0);
        push_request(OP_SEARCH, MOST_NEGATIVE);

        // fill past capacity so the full refusal and ring wrap are hit early
        for (k = 0; k < CAPACITY + 4; k++) begin
            op = $urandom_range(0, 1) ? OP_INSERT_FRONT : OP_APPEND_BACK;
            push_request(op, pick_value());
        end
        push_request(OP_SEARCH, recent_values[$urandom_range(0, recent_values.size() - 1)]);
        push_request(OP_CLEAR, pick_value());

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            kind = (r < 35) ? PH_FILL : (r < 60) ? PH_DRAIN : (r < 90) ? PH_MIXED : PH_NOISE;
            phase_len = $urandom_range(8, 40);
            for (k = 0; k < phase_len; k++) begin
                r = $urandom_range(0, 99);
                case (kind)
                    PH_FILL: begin
                        op = (r < 35) ? OP_INSERT_FRONT : (r < 70) ? OP_APPEND_BACK :
                             (r < 88) ? OP_SEARCH : OP_REMOVE_BACK;
                    end
                    PH_DRAIN: begin
                        op = (r < 60) ? OP_REMOVE_BACK : (r < 80) ? OP_SEARCH :
                             (r < 90) ? OP_INSERT_FRONT : OP_APPEND_BACK;
                    end
                    PH_MIXED: begin
                        if (r < 22) begin
                            op = OP_INSERT_FRONT;
                        end else if (r < 44) begin
                            op = OP_APPEND_BACK;
                        end else if (r < 66) begin
                            op = OP_REMOVE_BACK;
                        end else if (r < 92) begin
                            op = OP_SEARCH;
                        end else if (r < 96) begin
                            op = OP_CLEAR;
                        end else begin
                            op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                        end
                    end
                    default: begin
                        op = OP_W'($urandom_range(0, 7));
                    end
                endcase
                if (op == OP_SEARCH && recent_values.size() != 0 && $urandom_range(0, 9) < 6) begin
                    value = recent_values[$urandom_range(0, recent_values.size() - 1)];
                end else begin
                    value = pick_value();
                end
                push_request(op, value);
            end
            if (kind == PH_FILL && $urandom_range(0, 4) == 0) begin
                push_request(OP_CLEAR, pick_value());
            end
            if (!hold_done && items_sent >= 400) begin
                long_hold_req = 1'b1;
                hold_done     = 1'b1;
            end
            if ((!pause_done && items_sent >= 800) || $urandom_range(0, 24) == 0) begin
                pause_done = 1'b1;
                wait_until_drained();
            end
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> deque_with_membership_search_core.f
design/dqs_pkg.sv
design/dqs_ram.sv
design/deque_with_membership_search_core.sv
tb/deque_result_checker.sv
tb/tb_deque_with_membership_search_core.sv
